// File: sv/obdpr_pkg.sv
// Shared types, codes and constant tables for the OBD PID request responder.
// No dependencies; imported by every module of the block.
package obdpr_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_SET     = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_VIN_0_3   = 3'd0;
    localparam logic [2:0] CFG_VIN_4_7   = 3'd1;
    localparam logic [2:0] CFG_VIN_8_11  = 3'd2;
    localparam logic [2:0] CFG_VIN_12_15 = 3'd3;
    localparam logic [2:0] CFG_VIN_16    = 3'd4;

    localparam logic [31:0] VIN_0_3_RESET   = 32'd877932866;
    localparam logic [31:0] VIN_4_7_RESET   = 32'd1177765195;
    localparam logic [31:0] VIN_8_11_RESET  = 32'd943805745;
    localparam logic [31:0] VIN_12_15_RESET = 32'd842216501;
    localparam logic [7:0]  VIN_16_RESET    = 8'd54;

    localparam logic [10:0] ID_BROADCAST = 11'h7DF;
    localparam logic [10:0] ID_DIRECT    = 11'h7E0;

    localparam logic [7:0] MODE_CURRENT = 8'h01;
    localparam logic [7:0] MODE_DTC     = 8'h03;
    localparam logic [7:0] MODE_VEHICLE = 8'h09;

    localparam logic [7:0] PID_SUPPORT_00 = 8'h00;
    localparam logic [7:0] PID_SUPPORT_20 = 8'h20;
    localparam logic [7:0] PID_SUPPORT_40 = 8'h40;
    localparam logic [7:0] PID_RUNTIME    = 8'h1F;
    localparam logic [7:0] PID_RPM        = 8'h0C;
    localparam logic [7:0] PID_VIN        = 8'h02;

    localparam logic [31:0] MASK_00 = 32'h1E3F8001;
    localparam logic [31:0] MASK_20 = 32'h00022001;
    localparam logic [31:0] MASK_40 = 32'h44001000;

    localparam logic [7:0] SF_LEN6     = 8'h06;
    localparam logic [7:0] RSP_CURRENT = 8'h41;
    localparam logic [7:0] RSP_DTC     = 8'h43;
    localparam logic [7:0] RSP_VEHICLE = 8'h49;
    localparam logic [7:0] FF_HEAD     = 8'h10;
    localparam logic [7:0] FF_LEN      = 8'h14;
    localparam logic [7:0] CF_SEQ1     = 8'h21;
    localparam logic [7:0] CF_SEQ2     = 8'h22;

    localparam int VALUE_SLOTS_DEFAULT = 16;
    localparam int KNOWN_SLOTS         = 16;
    localparam int SLOT_IDX_W          = 4;

    localparam logic [7:0] SLOT_PID [KNOWN_SLOTS] = '{
        8'h04, 8'h05, 8'h06, 8'h07, 8'h0B, 8'h0C, 8'h0D, 8'h0E,
        8'h0F, 8'h10, 8'h11, 8'h2F, 8'h33, 8'h42, 8'h46, 8'h5C
    };
    localparam logic [15:0] SLOT_RESET [KNOWN_SLOTS] = '{
        16'd128, 16'd130, 16'd128, 16'd128, 16'd101, 16'd2500, 16'd35, 16'd148,
        16'd75, 16'd320, 16'd25, 16'd166, 16'd101, 16'd14200, 16'd65, 16'd135
    };

    // Store access asked for by the frame builder
    typedef struct packed {
        logic                  wr_en;
        logic                  tick;
        logic [SLOT_IDX_W-1:0] slot;
        logic [15:0]           wr_data;
    } store_req_t;

    // One result frame, or none
    typedef struct packed {
        logic        has_frame;
        logic        last;
        logic [63:0] bytes;
    } frame_t;

    function automatic logic is_wide(input logic [7:0] pid);
        return (pid == 8'h0C) || (pid == 8'h10) || (pid == 8'h42);
    endfunction

    // Slot lookup: {hit, index}
    function automatic logic [SLOT_IDX_W:0] find_slot(input logic [7:0] pid);
        logic [SLOT_IDX_W:0] res;
        res = '0;
        for (int i = KNOWN_SLOTS - 1; i >= 0; i--) begin
            if (SLOT_PID[i] == pid) begin
                res = {1'b1, SLOT_IDX_W'(i)};
            end
        end
        return res;
    endfunction

endpackage

// File: sv/obd_pid_request_responder_top.sv
// Top level of the OBD PID request responder: input register, frame
// sequencer, VIN registers and output register. Depends on obdpr_pkg,
// obdpr_value_store and obdpr_frame_builder.
//
// Usage:
//  - s_ channel carries one item per transfer: a received request frame,
//    a write of a stored PID value, or a one-second tick (kind on s_tuser).
//  - m_ channel carries response frames, eight data bytes each; m_tlast
//    marks the final frame of a response (every single frame, and the
//    third frame of a VIN answer).
//  - cfg_ channel writes the VIN registers; it is always ready. Write only
//    while no item is in flight.
//  - Path: an item is captured in the input register, and each of its frames is
//    then registered in the output register that drives m_.
//  - Throughput: one item per cycle for items that give zero or one frame while
//    m_tready is high; a VIN request holds the input register until all three of its frames have been sent.
//  - Reset (aresetn low, synchronous) empties both registers, restores the
//    default PID values, clears the seconds counter and loads the default VIN.
//  - When m_tready is low the output register holds its frame; the input
//    register holds its item until its frames move on, and s_tready drops.
module obd_pid_request_responder_top
    import obdpr_pkg::*;
#(
    parameter int VALUE_SLOTS = VALUE_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [10:0] request_id, [18:11] service_mode, [26:19] pid_byte,
    // [42:27] set_value, [47:43] zero
    input  logic [47:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [63:0] frame_bytes
    output logic [63:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  op_reg;
    logic [42:0] data_reg;
    logic [1:0]  frame_idx_reg, frame_idx_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg;
    logic        out_last_reg;

    // VIN registers
    logic [31:0] vin0_reg, vin1_reg, vin2_reg, vin3_reg;
    logic [7:0]  vin16_reg;

    frame_t      frame;
    store_req_t  req;
    logic [15:0] stored_value;
    logic [15:0] seconds;
    logic        out_free;
    logic        emit;
    logic        done;
    logic        take;

    // Output register frees when empty or when its frame transfers
    assign out_free = !out_valid_reg || m_tready;
    assign emit     = in_valid_reg && frame.has_frame && out_free;
    // Release the held item once it has nothing more to send
    assign done     = in_valid_reg && (!frame.has_frame || (out_free && frame.last));
    assign s_tready = !in_valid_reg || done;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (done) begin
            in_valid_next = 1'b0;
        end
        frame_idx_next = frame_idx_reg;
        if (emit) begin
            frame_idx_next = frame.last ? 2'd0 : frame_idx_reg + 2'd1;
        end
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            frame_idx_reg <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            frame_idx_reg <= frame_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on transfer, hold otherwise
    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg   <= s_tuser;
            data_reg <= s_tdata[42:0];
        end
        if (emit) begin
            out_data_reg <= frame.bytes;
            out_last_reg <= frame.last;
        end
    end

    // VIN configuration registers; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vin0_reg  <= VIN_0_3_RESET;
            vin1_reg  <= VIN_4_7_RESET;
            vin2_reg  <= VIN_8_11_RESET;
            vin3_reg  <= VIN_12_15_RESET;
            vin16_reg <= VIN_16_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_VIN_0_3:   vin0_reg  <= cfg_wdata;
                CFG_VIN_4_7:   vin1_reg  <= cfg_wdata;
                CFG_VIN_8_11:  vin2_reg  <= cfg_wdata;
                CFG_VIN_12_15: vin3_reg  <= cfg_wdata;
                CFG_VIN_16:    vin16_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    obdpr_frame_builder u_builder (
        .operation    (op_reg),
        .request_id   (data_reg[10:0]),
        .service_mode (data_reg[18:11]),
        .pid_byte     (data_reg[26:19]),
        .set_value    (data_reg[42:27]),
        .frame_idx    (frame_idx_reg),
        .stored_value (stored_value),
        .seconds      (seconds),
        .vin          ({vin0_reg, vin1_reg, vin2_reg, vin3_reg, vin16_reg}),
        .frame        (frame),
        .req          (req)
    );

    // Store writes and ticks take effect in the single cycle the item is released
    obdpr_value_store #(
        .VALUE_SLOTS (VALUE_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_en  (done),
        .req     (req),
        .rd_data (stored_value),
        .seconds (seconds)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: sv/obdpr_value_store.sv
// Parameter value store and seconds counter of the OBD PID responder.
// Depends on obdpr_pkg.
module obdpr_value_store
    import obdpr_pkg::*;
#(
    parameter int VALUE_SLOTS = VALUE_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        req_en,
    input  store_req_t  req,
    output logic [15:0] rd_data,
    output logic [15:0] seconds
);
    localparam int SLOT_W = $clog2(VALUE_SLOTS);

    logic [15:0]       store_reg [VALUE_SLOTS];
    logic [15:0]       seconds_reg;
    logic [SLOT_W-1:0] slot_ext;

    assign slot_ext = SLOT_W'(req.slot);

    for (genvar g = 0; g < VALUE_SLOTS; g++) begin : g_slot
        localparam logic [15:0] RST = (g < KNOWN_SLOTS) ? SLOT_RESET[g % KNOWN_SLOTS] : 16'd0;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                store_reg[g] <= RST;
            end else if (req_en && req.wr_en && (slot_ext == SLOT_W'(g))) begin
                store_reg[g] <= req.wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seconds_reg <= '0;
        end else if (req_en && req.tick) begin
            seconds_reg <= seconds_reg + 16'd1;
        end
    end

    assign rd_data = store_reg[slot_ext];
    assign seconds = seconds_reg;

endmodule

// File: sv/obdpr_frame_builder.sv
// Decode of one held item into a response frame and a store access.
// Depends on obdpr_pkg.
module obdpr_frame_builder
    import obdpr_pkg::*;
(
    input  logic [1:0]   operation,
    input  logic [10:0]  request_id,
    input  logic [7:0]   service_mode,
    input  logic [7:0]   pid_byte,
    input  logic [15:0]  set_value,
    input  logic [1:0]   frame_idx,
    input  logic [15:0]  stored_value,
    input  logic [15:0]  seconds,
    input  logic [135:0] vin,
    output frame_t       frame,
    output store_req_t   req
);
    logic [SLOT_IDX_W:0] lookup;
    logic                id_ok;
    logic [15:0]         value;

    assign lookup = find_slot(pid_byte);
    assign id_ok  = (request_id == ID_BROADCAST) || (request_id == ID_DIRECT);
    // RPM is reported as four times the stored value, wrapped to 16 bits
    assign value  = (pid_byte == PID_RPM) ? {stored_value[13:0], 2'b00} : stored_value;

    always_comb begin
        frame       = '0;
        frame.last  = 1'b1;
        req.wr_en   = 1'b0;
        req.tick    = 1'b0;
        req.slot    = lookup[SLOT_IDX_W-1:0];
        req.wr_data = is_wide(pid_byte) ? set_value : {8'h00, set_value[7:0]};
        unique case (operation)
            OP_SET:  req.wr_en = lookup[SLOT_IDX_W];
            OP_TICK: req.tick  = 1'b1;
            OP_REQUEST: begin
                if (id_ok) begin
                    priority if (service_mode == MODE_CURRENT) begin
                        frame.has_frame = 1'b1;
                        priority if (pid_byte == PID_SUPPORT_00) begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, MASK_00, 8'h00};
                        end else if (pid_byte == PID_SUPPORT_20) begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, MASK_20, 8'h00};
                        end else if (pid_byte == PID_SUPPORT_40) begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, MASK_40, 8'h00};
                        end else if (pid_byte == PID_RUNTIME) begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, seconds, 24'h0};
                        end else if (!lookup[SLOT_IDX_W]) begin
                            frame.has_frame = 1'b0;
                        end else if (is_wide(pid_byte)) begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, value, 24'h0};
                        end else begin
                            frame.bytes = {SF_LEN6, RSP_CURRENT, pid_byte, value[7:0], 32'h0};
                        end
                    end else if (service_mode == MODE_VEHICLE) begin
                        priority if (pid_byte == PID_SUPPORT_00) begin
                            frame.has_frame = 1'b1;
                            frame.bytes = {SF_LEN6, RSP_VEHICLE, 24'h0, 8'h40, 16'h0};
                        end else if (pid_byte == PID_VIN) begin
                            frame.has_frame = 1'b1;
                            frame.last      = (frame_idx == 2'd2);
                            priority if (frame_idx == 2'd0) begin
                                frame.bytes = {FF_HEAD, FF_LEN, RSP_VEHICLE, PID_VIN, 8'h01,
                                               vin[135:112]};
                            end else if (frame_idx == 2'd1) begin
                                frame.bytes = {CF_SEQ1, vin[111:56]};
                            end else begin
                                frame.bytes = {CF_SEQ2, vin[55:0]};
                            end
                        end else begin
                            frame.has_frame = 1'b0;
                        end
                    end else if (service_mode == MODE_DTC) begin
                        frame.has_frame = 1'b1;
                        frame.bytes = {SF_LEN6, RSP_DTC, 48'h0};
                    end else begin
                        frame.has_frame = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
